### rtl/mfb_pkg.sv
// Shared types and constants for the max-flow search block.
// No dependencies.
`default_nettype none
package mfb_pkg;
    localparam int NODE_COUNT = 64;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int CELL_W     = 2 * NODE_W;
    localparam int CAP_W      = 16;
    localparam int FLOW_W     = 22;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_RUN   = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // One matrix port request: read or write.
    typedef struct packed {
        logic              we;
        logic [CELL_W-1:0] addr;
        logic [CAP_W-1:0]  wdata;
    } t_mreq;
endpackage
`default_nettype wire

### rtl/mfb_matrix.sv
// Residual capacity matrix: one synchronous port with registered read data.
// Depends on mfb_pkg.
`default_nettype none
module mfb_matrix (
    input  wire                       i_clk,
    input  mfb_pkg::t_mreq            i_req,
    output logic [mfb_pkg::CAP_W-1:0] o_rdata
);
    import mfb_pkg::*;
    logic [CAP_W-1:0] r_mem [NODE_COUNT*NODE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end
endmodule
`default_nettype wire

### rtl/max_flow_bfs_augmenting_top.sv
// Max-flow top: command decode, BFS sequencer, path augment, result strobe.
// Depends on mfb_pkg and mfb_matrix.
//
//  channel  | ports                                           | handshake
//  ---------+-------------------------------------------------+----------------
//  request  | i_func i_edge_tail i_edge_head i_edge_capacity  | i_start, o_busy
//           | i_source_node i_sink_node                       |
//  result   | o_total_flow                                    | o_done (1 cycle)
//
// Loads write the forward entry at accept, then the reverse entry with busy high.
// Clear sweeps the whole matrix, one entry a cycle.
// Reset runs the same clearing pass with busy high.
// A run repeats a breadth-first search and, per path found, a bottleneck pass
// and an augment pass along the path, all on the single matrix port.
// The receiver cannot stall; o_done is asserted for one cycle per run.
`default_nettype none
module max_flow_bfs_augmenting_top (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    output logic                       o_busy,
    input  wire  [1:0]                 i_func,
    input  wire  [5:0]                 i_edge_tail,
    input  wire  [5:0]                 i_edge_head,
    input  wire  [15:0]                i_edge_capacity,
    input  wire  [5:0]                 i_source_node,
    input  wire  [5:0]                 i_sink_node,
    output logic                       o_done,
    output logic [21:0]                o_total_flow
);
    import mfb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_LOAD2, S_BFS_INIT, S_BFS_POP, S_BFS_DEQ, S_BFS_SCAN,
        S_BFS_CHK, S_MIN_RD, S_MIN_PAR, S_MIN_WT, S_SUB_RD, S_SUB_PAR, S_SUB_WT,
        S_ADD_RD, S_ADD_WT, S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CELL_W-1:0]   r_cnt, n_cnt;
    logic [NODE_W-1:0]   r_src, n_src, r_dst, n_dst;
    logic [NODE_W-1:0]   r_cur, n_cur, r_to, n_to, r_from, n_from;
    logic [NODE_W-1:0]   r_idx, n_idx;      // scan index
    logic                r_idx_v, n_idx_v;  // a read for r_idx - 1 is in flight
    logic [NODE_W:0]     r_qh, n_qh, r_qt, n_qt;
    logic [NODE_COUNT-1:0] r_pv, n_pv;
    logic [CAP_W:0]      r_bn, n_bn;
    logic [FLOW_W-1:0]   r_tot, n_tot;
    logic [NODE_W-1:0]   r_ld_t, n_ld_t, r_ld_h, n_ld_h;
    logic [NODE_W-1:0]   r_parent [NODE_COUNT];
    logic [NODE_W-1:0]   r_queue  [NODE_COUNT];
    logic [NODE_W-1:0]   r_p_rdata, r_q_rdata;
    logic                par_we, q_we;
    logic [NODE_W-1:0]   par_wa, par_wd, q_wa, q_wd;
    logic                r_done, n_done;
    t_mreq               mreq;
    logic [CAP_W-1:0]    rdata;

    mfb_matrix u_matrix (.i_clk(i_clk), .i_req(mreq), .o_rdata(rdata));

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_total_flow = r_tot;

    logic [NODE_W-1:0] last_idx;
    assign last_idx = NODE_W'(NODE_COUNT - 1);

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_src = r_src; n_dst = r_dst;
        n_cur = r_cur; n_to = r_to; n_from = r_from; n_idx = r_idx;
        n_idx_v = 1'b0; n_qh = r_qh; n_qt = r_qt; n_pv = r_pv; n_bn = r_bn;
        n_tot = r_tot; n_ld_t = r_ld_t; n_ld_h = r_ld_h;
        n_done = 1'b0;
        mreq = '0;
        par_we = 1'b0; par_wa = '0; par_wd = '0;
        q_we = 1'b0; q_wa = '0; q_wd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (t_func'(i_func))
                        FUNC_CLEAR: begin
                            n_cnt = '0; n_state = S_CLEAR;
                        end
                        FUNC_LOAD: begin
                            // forward entry now; reverse entry next cycle
                            mreq.we = 1'b1;
                            mreq.addr = {i_edge_tail, i_edge_head};
                            mreq.wdata = i_edge_capacity;
                            n_ld_t = i_edge_tail; n_ld_h = i_edge_head;
                            n_state = S_LOAD2;
                        end
                        FUNC_RUN: begin
                            n_src = i_source_node; n_dst = i_sink_node;
                            n_tot = '0;
                            n_state = (i_source_node == i_sink_node) ? S_DONE
                                                                     : S_BFS_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                mreq.we = 1'b1; mreq.addr = r_cnt;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CELL_W'(NODE_COUNT*NODE_COUNT - 1)) n_state = S_IDLE;
            end
            S_LOAD2: begin
                mreq.we = 1'b1; mreq.addr = {r_ld_h, r_ld_t};
                n_state = S_IDLE;
            end
            S_BFS_INIT: begin
                n_pv = '0; n_pv[r_src] = 1'b1;
                par_we = 1'b1; par_wa = r_src; par_wd = r_src;
                q_we = 1'b1; q_wa = '0; q_wd = r_src;
                n_qh = '0; n_qt = (NODE_W+1)'(1);
                n_state = S_BFS_POP;
            end
            S_BFS_POP: begin
                // queue head is read this cycle, registered for S_BFS_DEQ
                if (r_pv[r_dst]) begin
                    n_bn = {1'b1, {CAP_W{1'b0}}}; n_to = r_dst; n_state = S_MIN_RD;
                end else if (r_qh < r_qt) begin
                    n_state = S_BFS_DEQ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BFS_DEQ: begin
                n_cur = r_q_rdata;
                n_qh = r_qh + 1'b1; n_idx = '0; n_state = S_BFS_SCAN;
            end
            S_BFS_SCAN: begin
                // issue read for r_idx, evaluate the one issued last cycle
                mreq.addr = {r_cur, r_idx};
                n_idx_v = 1'b1;
                if (r_idx_v && rdata != '0 && !r_pv[r_idx - 1'b1]) begin
                    n_pv[r_idx - 1'b1] = 1'b1;
                    par_we = 1'b1; par_wa = r_idx - 1'b1; par_wd = r_cur;
                    if (r_qt < (NODE_W+1)'(NODE_COUNT)) begin
                        q_we = 1'b1; q_wa = r_qt[NODE_W-1:0]; q_wd = r_idx - 1'b1;
                        n_qt = r_qt + 1'b1;
                    end
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == last_idx) n_state = S_BFS_CHK;
            end
            S_BFS_CHK: begin
                if (rdata != '0 && !r_pv[last_idx]) begin
                    n_pv[last_idx] = 1'b1;
                    par_we = 1'b1; par_wa = last_idx; par_wd = r_cur;
                    if (r_qt < (NODE_W+1)'(NODE_COUNT)) begin
                        q_we = 1'b1; q_wa = r_qt[NODE_W-1:0]; q_wd = last_idx;
                        n_qt = r_qt + 1'b1;
                    end
                end
                n_state = S_BFS_POP;
            end
            S_MIN_RD: begin
                // parent of r_to is read this cycle, registered for S_MIN_PAR
                if (r_to == r_src) begin
                    n_to = r_dst; n_state = S_SUB_RD;
                end else begin
                    n_state = S_MIN_PAR;
                end
            end
            S_MIN_PAR: begin
                n_from = r_p_rdata;
                mreq.addr = {r_p_rdata, r_to};
                n_state = S_MIN_WT;
            end
            S_MIN_WT: begin
                if ({1'b0, rdata} < r_bn) n_bn = {1'b0, rdata};
                n_to = r_from; n_state = S_MIN_RD;
            end
            S_SUB_RD: begin
                if (r_to == r_src) begin
                    n_tot = r_tot + FLOW_W'(r_bn); n_state = S_BFS_INIT;
                end else begin
                    n_state = S_SUB_PAR;
                end
            end
            S_SUB_PAR: begin
                n_from = r_p_rdata;
                mreq.addr = {r_p_rdata, r_to};
                n_state = S_SUB_WT;
            end
            S_SUB_WT: begin
                mreq.we = 1'b1; mreq.addr = {r_from, r_to};
                mreq.wdata = rdata - r_bn[CAP_W-1:0];
                n_state = S_ADD_RD;
            end
            S_ADD_RD: begin
                mreq.addr = {r_to, r_from}; n_state = S_ADD_WT;
            end
            S_ADD_WT: begin
                mreq.we = 1'b1; mreq.addr = {r_to, r_from};
                mreq.wdata = rdata + r_bn[CAP_W-1:0];
                n_to = r_from; n_state = S_SUB_RD;
            end
            S_DONE: begin
                n_done = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_cnt <= '0; r_done <= 1'b0; r_idx_v <= 1'b0;
            r_pv <= '0; r_tot <= '0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_done <= n_done;
            r_idx_v <= n_idx_v; r_pv <= n_pv; r_tot <= n_tot;
        end
        r_src <= n_src; r_dst <= n_dst; r_cur <= n_cur; r_to <= n_to;
        r_from <= n_from; r_idx <= n_idx; r_qh <= n_qh; r_qt <= n_qt;
        r_bn <= n_bn; r_ld_t <= n_ld_t; r_ld_h <= n_ld_h;
        if (par_we) r_parent[par_wa] <= par_wd;
        if (q_we) r_queue[q_wa] <= q_wd;
        r_p_rdata <= r_parent[r_to];
        r_q_rdata <= r_queue[r_qh[NODE_W-1:0]];
    end
endmodule
`default_nettype wire

### sim/tb.sv
// Testbench for max_flow_bfs_augmenting_top: random edge loads, clears and max-flow runs,
// checked against an in-bench Edmonds-Karp predictor.
// Depends on mfb_pkg and the max-flow RTL.
`timescale 1ns / 100ps
module tb;
    import mfb_pkg::*;

    typedef struct {
        t_func       func;
        logic [5:0]  tail;
        logic [5:0]  head;
        logic [15:0] cap;
        logic [5:0]  src;
        logic [5:0]  snk;
    } t_request;

    localparam int LIMIT_CYCLES = 100_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_func = FUNC_NONE;
    logic [5:0]  i_edge_tail = '0;
    logic [5:0]  i_edge_head = '0;
    logic [15:0] i_edge_capacity = '0;
    logic [5:0]  i_source_node = '0;
    logic [5:0]  i_sink_node = '0;
    logic        o_busy;
    logic        o_done;
    logic [21:0] o_total_flow;

    max_flow_bfs_augmenting_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_func(i_func), .i_edge_tail(i_edge_tail), .i_edge_head(i_edge_head),
        .i_edge_capacity(i_edge_capacity), .i_source_node(i_source_node),
        .i_sink_node(i_sink_node), .o_done(o_done), .o_total_flow(o_total_flow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_request           pending_requests[$];
    logic [21:0]        expected_flows[$];
    int unsigned        resid[NODE_COUNT][NODE_COUNT];
    int                 errors = 0;
    int                 accepted = 0;
    int                 total_items = 0;
    int                 n_runs = 0, n_loads = 0, n_clears = 0, n_flow_nonzero = 0;
    longint             cycles = 0;

    // Edmonds-Karp over the predicted residual matrix.
    function automatic logic [21:0] max_flow(int s, int t);
        bit          seen[NODE_COUNT];
        int          parent[NODE_COUNT];
        int          bfs_q[NODE_COUNT];
        int          qh, qt, cur, v, hops;
        int unsigned bottleneck, total;
        total = 0;
        if (s == t) return '0;
        forever begin
            foreach (seen[k]) begin
                seen[k] = 0;
                parent[k] = 0;
            end
            seen[s] = 1;
            parent[s] = s;
            bfs_q[0] = s;
            qh = 0;
            qt = 1;
            while (qh < qt && !seen[t]) begin
                cur = bfs_q[qh];
                qh++;
                for (int k = 0; k < NODE_COUNT; k++) begin
                    if (resid[cur][k] > 0 && !seen[k]) begin
                        seen[k] = 1;
                        parent[k] = cur;
                        if (qt < NODE_COUNT) begin
                            bfs_q[qt] = k;
                            qt++;
                        end
                    end
                end
            end
            if (!seen[t]) break;
            bottleneck = 65536;
            v = t;
            hops = 0;
            while (v != s && hops < NODE_COUNT) begin
                if (resid[parent[v]][v] < bottleneck) bottleneck = resid[parent[v]][v];
                v = parent[v];
                hops++;
            end
            v = t;
            hops = 0;
            while (v != s && hops < NODE_COUNT) begin
                resid[parent[v]][v] -= bottleneck;
                resid[v][parent[v]] += bottleneck;
                v = parent[v];
                hops++;
            end
            total += bottleneck;
        end
        return total[21:0];
    endfunction

    task automatic apply_request(t_request r);
        case (r.func)
            FUNC_CLEAR: begin
                foreach (resid[a, b]) resid[a][b] = 0;
                n_clears++;
            end
            FUNC_LOAD: begin
                resid[r.tail][r.head] = r.cap;
                resid[r.head][r.tail] = 0;
                n_loads++;
            end
            FUNC_RUN: begin
                expected_flows.push_back(max_flow(r.src, r.snk));
                n_runs++;
            end
            default: ;
        endcase
    endtask

    function automatic t_request mk(t_func f, int tl, int hd, int cp, int s, int t);
        t_request r;
        r.func = f;
        r.tail = 6'(tl);
        r.head = 6'(hd);
        r.cap  = 16'(cp);
        r.src  = 6'(s);
        r.snk  = 6'(t);
        return r;
    endfunction

    function automatic int rand_cap();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            2, 3:    return $urandom_range(0, 15);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Sender idle percentage by phase of the run.
    function automatic int idle_pct();
        case (accepted * 4 / (total_items + 1))
            1:       return 77;
            3:       return 6;
            default: return 0;
        endcase
    endfunction

    // Driver: advance on accept, hold while busy.
    always @(posedge i_clk) begin
        t_request r;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                apply_request(mk(t_func'(i_func), i_edge_tail, i_edge_head,
                                 i_edge_capacity, i_source_node, i_sink_node));
                accepted++;
            end
            if (!i_start || !o_busy) begin
                if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct()) begin
                    r = pending_requests.pop_front();
                    i_start         <= 1'b1;
                    i_func          <= r.func;
                    i_edge_tail     <= r.tail;
                    i_edge_head     <= r.head;
                    i_edge_capacity <= r.cap;
                    i_source_node   <= r.src;
                    i_sink_node     <= r.snk;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        logic [21:0] exp_flow;
        if (i_rst_n && o_done) begin
            if (expected_flows.size() == 0) begin
                $display("%0t: unexpected result, actual total_flow %0d", $time, o_total_flow);
                errors++;
            end else begin
                exp_flow = expected_flows.pop_front();
                if (exp_flow != o_total_flow) begin
                    $display("%0t: total_flow mismatch, expected %0d actual %0d",
                             $time, exp_flow, o_total_flow);
                    errors++;
                end else if (exp_flow != 0) begin
                    n_flow_nonzero++;
                end
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int base, k, n, s, t;
        // Directed: extremes, reverse zeroing, self loop, degenerate runs, unused code.
        pending_requests.push_back(mk(FUNC_RUN, 0, 0, 0, 0, 63));
        pending_requests.push_back(mk(FUNC_LOAD, 0, 63, 65535, 0, 0));
        pending_requests.push_back(mk(FUNC_RUN, 0, 0, 0, 0, 63));
        pending_requests.push_back(mk(FUNC_RUN, 0, 0, 0, 63, 0));
        pending_requests.push_back(mk(FUNC_LOAD, 63, 0, 7, 0, 0));
        pending_requests.push_back(mk(FUNC_RUN, 0, 0, 0, 63, 0));
        pending_requests.push_back(mk(FUNC_LOAD, 5, 5, 100, 0, 0));
        pending_requests.push_back(mk(FUNC_RUN, 0, 0, 0, 5, 5));
        pending_requests.push_back(mk(FUNC_NONE, 63, 63, 65535, 63, 63));
        pending_requests.push_back(mk(FUNC_LOAD, 1, 2, 10, 0, 0));
        pending_requests.push_back(mk(FUNC_LOAD, 1, 3, 5, 0, 0));
        pending_requests.push_back(mk(FUNC_LOAD, 2, 3, 15, 0, 0));
        pending_requests.push_back(mk(FUNC_LOAD, 2, 4, 0, 0, 0));
        pending_requests.push_back(mk(FUNC_LOAD, 3, 4, 65535, 0, 0));
        pending_requests.push_back(mk(FUNC_RUN, 0, 0, 0, 1, 4));
        pending_requests.push_back(mk(FUNC_RUN, 0, 0, 0, 1, 4));
        pending_requests.push_back(mk(FUNC_CLEAR, 0, 0, 0, 0, 0));
        pending_requests.push_back(mk(FUNC_RUN, 0, 0, 0, 1, 4));
        pending_requests.push_back(mk(FUNC_LOAD, 62, 63, 65535, 0, 0));
        pending_requests.push_back(mk(FUNC_RUN, 0, 0, 0, 62, 63));

        // Random: small windowed graphs loaded, then run; some noise.
        while (pending_requests.size() < 1950) begin
            if ($urandom_range(0, 7) == 0)
                pending_requests.push_back(mk(FUNC_CLEAR, $urandom_range(0, 63),
                    $urandom_range(0, 63), $urandom, $urandom_range(0, 63),
                    $urandom_range(0, 63)));
            base = $urandom_range(0, 56);
            n = $urandom_range(3, 12);
            for (k = 0; k < n; k++)
                pending_requests.push_back(mk(FUNC_LOAD, base + $urandom_range(0, 7),
                    base + $urandom_range(0, 7), rand_cap(), $urandom_range(0, 63),
                    $urandom_range(0, 63)));
            s = base + $urandom_range(0, 7);
            t = base + $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0: pending_requests.push_back(mk(FUNC_NONE, $urandom_range(0, 63),
                       $urandom_range(0, 63), $urandom, s, t));
                1: pending_requests.push_back(mk(FUNC_RUN, $urandom_range(0, 63),
                       $urandom_range(0, 63), $urandom, $urandom_range(0, 63),
                       $urandom_range(0, 63)));
                default: ;
            endcase
            pending_requests.push_back(mk(FUNC_RUN, $urandom_range(0, 63),
                $urandom_range(0, 63), $urandom, s, t));
        end
        total_items = pending_requests.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_requests.size() == 0 && accepted == total_items);
        wait (expected_flows.size() == 0);
        @(posedge i_clk);
        wait (!o_busy);
        repeat (200) @(posedge i_clk);

        $display("tb: %0d requests: %0d loads, %0d clears, %0d runs (%0d with nonzero flow)",
                 total_items, n_loads, n_clears, n_runs, n_flow_nonzero);
        if (errors == 0 && expected_flows.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### sim.f
rtl/mfb_pkg.sv
rtl/mfb_matrix.sv
rtl/max_flow_bfs_augmenting_top.sv
sim/tb.sv
